// ===== hw/rtl/mttm_pkg.sv =====
// ----------------------------------------------------------------------------
// mttm_pkg
// shared constants and types for the masked template top-k matcher
// ----------------------------------------------------------------------------
`default_nettype none
package mttm_pkg;
    localparam int NUM_CHANNELS_DEF = 60;
    localparam int TOP_K_DEF        = 64;

    typedef enum logic [1:0] {
        ACT_EVENT    = 2'd0,
        ACT_TEMPLATE = 2'd1,
        ACT_READOUT  = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        CFG_MASK  = 1'b0,
        CFG_CALIB = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_DIV,
        ST_SQR,
        ST_ACC,
        ST_INSERT,
        ST_READ
    } state_t;

    // one list entry
    typedef struct packed {
        logic        used;
        logic [63:0] chi2;
        logic [63:0] labels;
    } entry_t;

    // control from top level to each cell
    typedef struct packed {
        logic        clear;
        logic        insert;
        logic        shift_out;
        logic [63:0] chi2;
        logic [63:0] labels;
    } cell_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mttm_cell.sv =====
// ----------------------------------------------------------------------------
// mttm_cell
// one slot of the sorted best list
// ----------------------------------------------------------------------------
`default_nettype none
module mttm_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mttm_pkg::cell_ctl_t ctl,
    input  wire mttm_pkg::entry_t   left,
    input  wire logic               left_le,
    input  wire mttm_pkg::entry_t   right,
    output mttm_pkg::entry_t        entry,
    output logic                    le_new
);
    mttm_pkg::entry_t entry_reg, entry_next;
    logic keep;

    assign entry  = entry_reg;
    // existing entry stays ahead of the new one on a tie
    assign le_new = entry_reg.used && (entry_reg.chi2 <= ctl.chi2);
    assign keep   = le_new;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.clear) begin
            entry_next.used = 1'b0;
        end else if (ctl.insert) begin
            if (keep) begin
                entry_next = entry_reg;
            end else if (left_le) begin
                entry_next.used   = 1'b1;
                entry_next.chi2   = ctl.chi2;
                entry_next.labels = ctl.labels;
            end else begin
                entry_next = left;
            end
        end else if (ctl.shift_out && entry_reg.used) begin
            // only filled slots rotate, empty ones stay empty
            entry_next = right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.used <= 1'b0;
        end else begin
            entry_reg.used <= entry_next.used;
        end
        entry_reg.chi2   <= entry_next.chi2;
        entry_reg.labels <= entry_next.labels;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mttm_chain.sv =====
// ----------------------------------------------------------------------------
// mttm_chain
// row of list cells; inserts in sorted order, rotates toward rank 0 on readout
// ----------------------------------------------------------------------------
`default_nettype none
module mttm_chain #(
    parameter int TOP_K = mttm_pkg::TOP_K_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mttm_pkg::cell_ctl_t ctl,
    output mttm_pkg::entry_t         head
);
    mttm_pkg::entry_t ent [TOP_K];
    mttm_pkg::entry_t lft [TOP_K];
    mttm_pkg::entry_t rgt [TOP_K];
    logic             le  [TOP_K];
    logic             lle [TOP_K];

    genvar g;
    generate
        for (g = 0; g < TOP_K; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign lft[g] = '0;
                assign lle[g] = 1'b1;
            end else begin : g_rest
                assign lft[g] = ent[g-1];
                assign lle[g] = le[g-1];
            end
            // last filled slot takes the head back, so a readout keeps the list
            if (g == TOP_K - 1) begin : g_end
                assign rgt[g] = ent[0];
            end else begin : g_mid
                assign rgt[g] = ent[g+1].used ? ent[g+1] : ent[0];
            end
            mttm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .left    (lft[g]),
                .left_le (lle[g]),
                .right   (rgt[g]),
                .entry   (ent[g]),
                .le_new  (le[g])
            );
        end
    endgenerate

    assign head = ent[0];
endmodule
`default_nettype wire

// ===== hw/rtl/masked_template_topk_matcher.sv =====
// ----------------------------------------------------------------------------
// masked_template_topk_matcher
// matches event channel times against streamed templates, keeps top-k list
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// s_       in         s_valid / s_ready      action, channel, times, labels
// m_       out        m_valid / m_ready      rank, chi2, labels, flags
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// event and template samples are taken in IDLE; a template sample on an enabled
// channel then passes through SQR and ACC (square, saturating add); a template's
// last sample then goes through INSERT for the cell-chain insert. the last event
// sample runs a mean pass over the NUM_CHANNELS channels and a restoring divide (33
// quotient bits and a finish step). readout gives one transaction per list
// entry (one for an empty list), rotating the chain once per transaction.
// reset is synchronous active low and empties the list; output stalls hold.
`default_nettype none
module masked_template_topk_matcher #(
    parameter int NUM_CHANNELS = mttm_pkg::NUM_CHANNELS_DEF,
    parameter int TOP_K        = mttm_pkg::TOP_K_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic [5:0]         s_channel,
    input  wire logic signed [23:0] s_time_value,
    input  wire logic signed [23:0] s_delay_time,
    input  wire logic               s_last,
    input  wire logic signed [15:0] s_cos_theta,
    input  wire logic [15:0]        s_phi,
    input  wire logic signed [15:0] s_cos_alpha,
    input  wire logic [15:0]        s_beta,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_rank,
    output logic [63:0]             m_chi2,
    output logic signed [15:0]      m_best_cos_theta,
    output logic [15:0]             m_best_phi,
    output logic signed [15:0]      m_best_cos_alpha,
    output logic [15:0]             m_best_beta,
    output logic                    m_valid_res,
    output logic                    m_final_res
);
    // event time store: one write port, one registered read port
    logic signed [24:0] evt_mem [64];
    logic signed [24:0] evt_rd_reg;

    logic [63:0] mask_reg;
    logic        calib_reg;

    mttm_pkg::state_t state_reg, state_next;

    logic [6:0]         ch_reg, ch_next;
    logic signed [31:0] sum_reg, sum_next;
    logic [6:0]         n_reg, n_next;
    logic signed [24:0] mean_reg, mean_next;
    logic [63:0]        acc_reg, acc_next;
    logic               last_reg, last_next;
    logic signed [23:0] tv_reg, tv_next;
    logic [63:0]        lab_reg, lab_next;
    logic [53:0]        sq_reg, sq_next;
    // divider: magnitude, remainder, quotient, step count
    logic [32:0]        dnum_reg, dnum_next;
    logic [32:0]        drem_reg, drem_next;
    logic [5:0]         dstep_reg, dstep_next;
    logic               dneg_reg, dneg_next;
    logic [6:0]         rd_cnt_reg, rd_cnt_next;
    logic [6:0]         count_reg, count_next;

    mttm_pkg::cell_ctl_t ctl;
    mttm_pkg::entry_t    head;

    logic s_fire, m_fire, chan_ok, chan_en, rd_en;
    logic [5:0] rd_addr;
    logic signed [26:0] diff;
    logic [26:0] adiff;
    logic [64:0] acc_sum;
    logic [33:0] drem_sh;

    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign chan_ok   = {1'b0, s_channel} < 7'(NUM_CHANNELS);
    assign chan_en   = chan_ok && mask_reg[s_channel];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= 64'h0FFF_FFFF_FFFF_FFFF;
            calib_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (mttm_pkg::cfg_idx_t'(cfg_index))
                mttm_pkg::CFG_MASK:  mask_reg  <= cfg_data;
                mttm_pkg::CFG_CALIB: calib_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // event store write and read
    assign rd_en   = (state_reg == mttm_pkg::ST_IDLE) || (state_reg == mttm_pkg::ST_MEAN);
    assign rd_addr = (state_reg == mttm_pkg::ST_MEAN) ? ch_reg[5:0] : s_channel;
    always_ff @(posedge aclk) begin
        if (s_fire && mttm_pkg::action_t'(s_action) == mttm_pkg::ACT_EVENT && chan_ok) begin
            evt_mem[s_channel] <= calib_reg ? (25'(s_time_value) - 25'(s_delay_time))
                                            : 25'(s_time_value);
        end
        if (rd_en) begin
            evt_rd_reg <= evt_mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mttm_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (mttm_pkg::action_t'(s_action))
                        mttm_pkg::ACT_EVENT:
                            if (s_last) state_next = mttm_pkg::ST_MEAN;
                        mttm_pkg::ACT_TEMPLATE:
                            if (chan_en) state_next = mttm_pkg::ST_SQR;
                            else if (s_last) state_next = mttm_pkg::ST_INSERT;
                        mttm_pkg::ACT_READOUT: state_next = mttm_pkg::ST_READ;
                        default: ;
                    endcase
                end
            end
            mttm_pkg::ST_MEAN:
                if (ch_reg == 7'(NUM_CHANNELS)) state_next = mttm_pkg::ST_DIV;
            mttm_pkg::ST_DIV:
                if (dstep_reg == 6'd33) state_next = mttm_pkg::ST_IDLE;
            mttm_pkg::ST_SQR: state_next = mttm_pkg::ST_ACC;
            mttm_pkg::ST_ACC:
                state_next = last_reg ? mttm_pkg::ST_INSERT : mttm_pkg::ST_IDLE;
            mttm_pkg::ST_INSERT: state_next = mttm_pkg::ST_IDLE;
            mttm_pkg::ST_READ:
                if (m_fire && (rd_cnt_reg + 7'd1 >= count_reg)) state_next = mttm_pkg::ST_IDLE;
            default: state_next = mttm_pkg::ST_IDLE;
        endcase
    end

    assign diff    = 27'(evt_rd_reg) - 27'(mean_reg) - 27'(tv_reg);
    assign adiff   = diff[26] ? 27'(-diff) : 27'(diff);
    assign acc_sum = {1'b0, acc_reg} + {11'd0, sq_reg};
    assign drem_sh = {drem_reg, dnum_reg[32]};

    // datapath
    always_comb begin
        ch_next     = ch_reg;
        sum_next    = sum_reg;
        n_next      = n_reg;
        mean_next   = mean_reg;
        acc_next    = acc_reg;
        last_next   = last_reg;
        tv_next     = tv_reg;
        lab_next    = lab_reg;
        sq_next     = sq_reg;
        dnum_next   = dnum_reg;
        drem_next   = drem_reg;
        dstep_next  = dstep_reg;
        dneg_next   = dneg_reg;
        rd_cnt_next = rd_cnt_reg;
        count_next  = count_reg;
        ctl         = '0;
        ctl.chi2    = acc_reg;
        ctl.labels  = lab_reg;
        case (state_reg)
            mttm_pkg::ST_IDLE: begin
                if (s_fire) begin
                    tv_next   = s_time_value;
                    last_next = s_last;
                    lab_next  = {s_cos_theta, s_phi, s_cos_alpha, s_beta};
                    ch_next   = '0;
                    sum_next  = '0;
                    n_next    = '0;
                    rd_cnt_next = '0;
                end
            end
            mttm_pkg::ST_MEAN: begin
                // read of channel ch_reg lands in evt_rd_reg on the next cycle
                if (ch_reg != 7'd0 && mask_reg[6'(ch_reg - 7'd1)]) begin
                    sum_next = sum_reg + 32'(evt_rd_reg);
                    n_next   = n_reg + 7'd1;
                end
                ch_next = ch_reg + 7'd1;
                if (ch_reg == 7'(NUM_CHANNELS)) begin
                    dneg_next  = sum_next[31];
                    dnum_next  = sum_next[31] ? 33'(-sum_next) : 33'(sum_next);
                    dnum_next  = dnum_next + 33'(n_next >> 1);
                    drem_next  = '0;
                    dstep_next = '0;
                end
            end
            mttm_pkg::ST_DIV: begin
                if (dstep_reg < 6'd33) begin
                    if (drem_sh >= {27'd0, n_reg}) begin
                        drem_next = 33'(drem_sh - {27'd0, n_reg});
                        dnum_next = {dnum_reg[31:0], 1'b1};
                    end else begin
                        drem_next = drem_sh[32:0];
                        dnum_next = {dnum_reg[31:0], 1'b0};
                    end
                    dstep_next = dstep_reg + 6'd1;
                end else begin
                    if (n_reg == 7'd0) mean_next = '0;
                    else mean_next = dneg_reg ? 25'(-dnum_reg) : 25'(dnum_reg);
                    acc_next   = '0;
                    count_next = '0;
                    ctl.clear  = 1'b1;
                end
            end
            mttm_pkg::ST_SQR: sq_next = 54'(adiff) * 54'(adiff);
            mttm_pkg::ST_ACC: begin
                acc_next = acc_sum[64] ? '1 : acc_sum[63:0];
            end
            mttm_pkg::ST_INSERT: begin
                ctl.insert = 1'b1;
                acc_next   = '0;
                if (count_reg < 7'(TOP_K)) count_next = count_reg + 7'd1;
            end
            mttm_pkg::ST_READ: begin
                if (m_fire) begin
                    rd_cnt_next   = rd_cnt_reg + 7'd1;
                    ctl.shift_out = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        s_ready          = (state_reg == mttm_pkg::ST_IDLE);
        m_valid          = (state_reg == mttm_pkg::ST_READ);
        m_rank           = rd_cnt_reg[5:0];
        m_valid_res      = count_reg != 7'd0;
        m_final_res      = (count_reg == 7'd0) || (rd_cnt_reg + 7'd1 == count_reg);
        m_chi2           = m_valid_res ? head.chi2 : '0;
        m_best_cos_theta = m_valid_res ? head.labels[63:48] : '0;
        m_best_phi       = m_valid_res ? head.labels[47:32] : '0;
        m_best_cos_alpha = m_valid_res ? head.labels[31:16] : '0;
        m_best_beta      = m_valid_res ? head.labels[15:0]  : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mttm_pkg::ST_IDLE;
            sum_reg    <= '0;
            n_reg      <= '0;
            mean_reg   <= '0;
            acc_reg    <= '0;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            ch_reg     <= '0;
            dstep_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            n_reg      <= n_next;
            mean_reg   <= mean_next;
            acc_reg    <= acc_next;
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            ch_reg     <= ch_next;
            dstep_reg  <= dstep_next;
        end
        last_reg <= last_next;
        tv_reg   <= tv_next;
        lab_reg  <= lab_next;
        sq_reg   <= sq_next;
        dnum_reg <= dnum_next;
        drem_reg <= drem_next;
        dneg_reg <= dneg_next;
    end

    mttm_chain #(.TOP_K(TOP_K)) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .head    (head)
    );
endmodule
`default_nettype wire
